// File: rtl/core/jbsd_pkg.sv
// ----------------------------------------------------------------------------
// jbsd_pkg
// Shared types, opcode names and the opcode length table of the bytecode
// stream decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jbsd_pkg;

  // Default width of the byte offset counter.
  localparam int PC_BITS_DEFAULT = 16;

  // Result kinds.
  localparam logic [2:0] KIND_INSTR     = 3'd0;
  localparam logic [2:0] KIND_CASE      = 3'd1;
  localparam logic [2:0] KIND_DEFAULT   = 3'd2;
  localparam logic [2:0] KIND_BAD_OP    = 3'd3;
  localparam logic [2:0] KIND_BAD_PAD   = 3'd4;
  localparam logic [2:0] KIND_TRUNCATED = 3'd5;

  // Opcodes that need special handling.
  localparam logic [7:0] OP_BIPUSH          = 8'h10;
  localparam logic [7:0] OP_SIPUSH          = 8'h11;
  localparam logic [7:0] OP_LDC             = 8'h12;
  localparam logic [7:0] OP_IINC            = 8'h84;
  localparam logic [7:0] OP_IFEQ            = 8'h99;
  localparam logic [7:0] OP_JSR             = 8'ha8;
  localparam logic [7:0] OP_RET             = 8'ha9;
  localparam logic [7:0] OP_TABLESWITCH     = 8'haa;
  localparam logic [7:0] OP_LOOKUPSWITCH    = 8'hab;
  localparam logic [7:0] OP_INVOKEINTERFACE = 8'hb9;
  localparam logic [7:0] OP_NEWARRAY        = 8'hbc;
  localparam logic [7:0] OP_WIDE            = 8'hc4;
  localparam logic [7:0] OP_MULTIANEWARRAY  = 8'hc5;
  localparam logic [7:0] OP_IFNULL          = 8'hc6;
  localparam logic [7:0] OP_IFNONNULL       = 8'hc7;
  localparam logic [7:0] OP_GOTO_W          = 8'hc8;
  localparam logic [7:0] OP_JSR_W           = 8'hc9;

  // Instruction length codes; lengths 1 to 5 stand for themselves.
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_VAR = 3'd7;

  // One byte of the code stream.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       end_of_code;
  } byte_req_t;

  // One decoded result.
  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        instr_pc;
    logic [7:0]         opcode;
    logic               is_wide;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] branch_offset;
    logic signed [31:0] branch_target;
    logic               has_target;
    logic               run_last;
  } result_t;

  // Total instruction length by opcode class.
  function automatic logic [2:0] op_len(input logic [7:0] op);
    logic [2:0] len;
    unique case (op) inside
      [8'h00:8'h0f], [8'h1a:8'h35], [8'h3b:8'h83], [8'h85:8'h98], [8'hac:8'hb1],
      8'hbe, 8'hbf, 8'hc2, 8'hc3:
        len = 3'd1;
      OP_BIPUSH, OP_LDC, [8'h15:8'h19], [8'h36:8'h3a], OP_RET, OP_NEWARRAY:
        len = 3'd2;
      OP_SIPUSH, OP_IINC, 8'h13, 8'h14, [8'hb2:8'hb8], 8'hbb, 8'hbd, 8'hc0, 8'hc1,
      [OP_IFEQ:OP_JSR], OP_IFNULL, OP_IFNONNULL:
        len = 3'd3;
      OP_MULTIANEWARRAY:
        len = 3'd4;
      OP_INVOKEINTERFACE, OP_GOTO_W, OP_JSR_W:
        len = 3'd5;
      OP_WIDE, OP_TABLESWITCH, OP_LOOKUPSWITCH:
        len = LEN_VAR;
      default:
        len = LEN_BAD;
    endcase
    return len;
  endfunction

  // Opcodes that the wide prefix may modify.
  function automatic logic wide_ok(input logic [7:0] op);
    logic ok;
    case (op) inside
      [8'h15:8'h19], [8'h36:8'h3a], OP_RET, OP_IINC: ok = 1'b1;
      default:                                        ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

// File: rtl/core/jvm_bytecode_stream_decoder.sv
// ----------------------------------------------------------------------------
// jvm_bytecode_stream_decoder
// Splits a method's bytecode stream into instructions, switch cases and
// error reports, with operands assembled and branch targets computed.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on the byte channel (byte_valid / byte_stall / byte_data),
//   one request per code byte; end_of_code marks the last byte of a method.
//   Decoded results leave on the result channel (result_valid /
//   result_stall / result_data). A byte gives zero, one or two results;
//   run_last marks the last result of each byte.
//   The decoder takes one byte per cycle while byte_stall is low. Each
//   byte is decoded in the cycle it is accepted and its results are
//   written into a four-entry result queue, so the first result is
//   visible in the cycle after the byte. byte_stall rises only when fewer
//   than two queue entries are free, which happens when results arrive
//   faster than the receiver drains them; the result queue port sets the
//   sustained rate at one result per cycle while result_stall is low.
//   A stalled result holds until taken. Reset (rst, synchronous) clears the
//   decode state to offset zero awaiting an opcode and empties the queue.
//   After an end_of_code byte the decode state is back in its reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jvm_bytecode_stream_decoder #(
  parameter int PC_BITS = jbsd_pkg::PC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  jbsd_pkg::byte_req_t byte_data,
  output logic                result_valid,
  input  logic                result_stall,
  output jbsd_pkg::result_t   result_data
);
  import jbsd_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Decode state.
  logic [PC_BITS-1:0] byte_offset, byte_offset_next;
  logic [4:0]         phase_count, phase_count_next;
  logic [7:0]         current_opcode, current_opcode_next;
  logic               wide_seen, wide_seen_next;
  logic [PC_BITS-1:0] insn_pc, insn_pc_next;
  logic [31:0]        operand_accum, operand_accum_next;
  logic [31:0]        default_offset, default_offset_next;
  logic [31:0]        switch_key, switch_key_next;
  logic [31:0]        entries_left, entries_left_next;
  logic               skip_to_end, skip_to_end_next;

  // Result queue.
  result_t            queue [QDEPTH];
  logic [QAW-1:0]     wr_ptr, rd_ptr;
  logic [QCW-1:0]     count, count_next;

  logic               take, pop;
  result_t            res_a, res_b, res_t, slot0, slot1;
  logic               a_v, b_v, t_v;
  logic [1:0]         nres;

  // Build one result record.
  function automatic result_t make_res(input logic [2:0] kind, input logic [31:0] pc32,
                                       input logic [7:0] opc, input logic wide,
                                       input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] off, input logic has);
    result_t r;
    r.kind          = kind;
    r.instr_pc      = pc32[15:0];
    r.opcode        = opc;
    r.is_wide       = wide;
    r.operand_a     = a;
    r.operand_b     = b;
    r.branch_offset = has ? off : 32'd0;
    r.branch_target = has ? pc32 + off : 32'd0;
    r.has_target    = has;
    r.run_last      = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  assign take         = byte_valid && !byte_stall;
  assign pop          = result_valid && !result_stall;
  assign byte_stall   = (count > QCW'(QDEPTH - 2));
  assign result_valid = (count != '0);
  assign result_data  = queue[rd_ptr];

  // Per-byte decode: next state and up to three candidate results.
  always_comb begin
    logic [2:0]  len;
    logic [31:0] pc32;
    logic [31:0] accn;
    logic [31:0] word;
    logic [1:0]  pad;
    logic [4:0]  h;
    logic        table_sw;
    logic [7:0]  b;

    byte_offset_next    = byte_offset;
    phase_count_next    = phase_count;
    current_opcode_next = current_opcode;
    wide_seen_next      = wide_seen;
    insn_pc_next        = insn_pc;
    operand_accum_next  = operand_accum;
    default_offset_next = default_offset;
    switch_key_next     = switch_key;
    entries_left_next   = entries_left;
    skip_to_end_next    = skip_to_end;
    a_v   = 1'b0;
    b_v   = 1'b0;
    t_v   = 1'b0;
    res_a = '0;
    res_b = '0;
    res_t = '0;

    b        = byte_data.code_byte;
    word     = {operand_accum[23:0], b};
    accn     = word;
    pad      = ~insn_pc[1:0];
    h        = phase_count - 5'd1 - {3'b000, pad};
    table_sw = (current_opcode == OP_TABLESWITCH);
    len      = LEN_BAD;
    pc32     = 32'(insn_pc);

    if (take) begin
      if (!skip_to_end) begin
        if (phase_count == 5'd0) begin
          // Opcode byte: start a new instruction.
          len                 = op_len(b);
          insn_pc_next        = byte_offset;
          pc32                = 32'(byte_offset);
          operand_accum_next  = '0;
          wide_seen_next      = 1'b0;
          current_opcode_next = b;
          if (len == LEN_BAD) begin
            a_v              = 1'b1;
            res_a            = make_res(KIND_BAD_OP, pc32, b, 1'b0, '0, '0, '0, 1'b0);
            skip_to_end_next = 1'b1;
          end else if (len == 3'd1) begin
            a_v   = 1'b1;
            res_a = make_res(KIND_INSTR, pc32, b, 1'b0, '0, '0, '0, 1'b0);
          end else begin
            wide_seen_next   = (b == OP_WIDE);
            phase_count_next = 5'd1;
          end
        end else if (wide_seen && phase_count == 5'd1) begin
          // Opcode modified by the wide prefix.
          if (wide_ok(b)) begin
            current_opcode_next = b;
            phase_count_next    = 5'd2;
          end else begin
            a_v              = 1'b1;
            res_a            = make_res(KIND_BAD_OP, pc32, b, 1'b1, '0, '0, '0, 1'b0);
            phase_count_next = 5'd0;
            skip_to_end_next = 1'b1;
          end
        end else if (!wide_seen && (current_opcode == OP_TABLESWITCH ||
                                    current_opcode == OP_LOOKUPSWITCH)) begin
          if (phase_count < 5'd16) begin
            // Switch header: padding, default, low/high or npairs.
            phase_count_next = phase_count + 5'd1;
            if (phase_count >= 5'd1 + {3'b000, pad}) begin
              operand_accum_next = accn;
              if (h == 5'd3) begin
                default_offset_next = accn;
              end else if (h == 5'd7 && table_sw) begin
                switch_key_next = accn;
              end else if (h == 5'd7) begin
                a_v   = 1'b1;
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0, accn, '0, '0, 1'b0);
                if (accn[31] || accn == 32'd0) begin
                  b_v   = 1'b1;
                  res_b = make_res(KIND_DEFAULT, pc32, current_opcode, 1'b0, '0, '0,
                                   default_offset, 1'b1);
                  phase_count_next = 5'd0;
                end else begin
                  entries_left_next = accn - 32'd1;
                  phase_count_next  = 5'd16;
                end
              end else if (h == 5'd11) begin
                a_v   = 1'b1;
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0, switch_key, accn,
                                 '0, 1'b0);
                if ($signed(accn) < $signed(switch_key)) begin
                  b_v   = 1'b1;
                  res_b = make_res(KIND_DEFAULT, pc32, current_opcode, 1'b0, '0, '0,
                                   default_offset, 1'b1);
                  phase_count_next = 5'd0;
                end else begin
                  entries_left_next = accn - switch_key;
                  phase_count_next  = 5'd16;
                end
              end
            end
          end else begin
            // Switch entries: key (lookupswitch only) and offset.
            operand_accum_next = accn;
            phase_count_next   = phase_count + 5'd1;
            if (!table_sw && phase_count == 5'd19) begin
              switch_key_next = accn;
            end
            if ((table_sw && phase_count == 5'd19) || (!table_sw && phase_count == 5'd23)) begin
              a_v   = 1'b1;
              res_a = make_res(KIND_CASE, pc32, current_opcode, 1'b0, switch_key, '0,
                               accn, 1'b1);
              if (entries_left == 32'd0) begin
                b_v   = 1'b1;
                res_b = make_res(KIND_DEFAULT, pc32, current_opcode, 1'b0, '0, '0,
                                 default_offset, 1'b1);
                phase_count_next = 5'd0;
              end else begin
                entries_left_next = entries_left - 32'd1;
                if (table_sw) begin
                  switch_key_next = switch_key + 32'd1;
                end
                phase_count_next = 5'd16;
              end
            end
          end
        end else begin
          // Fixed-length operands.
          if (wide_seen) begin
            len = (current_opcode == OP_IINC) ? 3'd6 : 3'd4;
          end else begin
            len = op_len(current_opcode);
          end
          if (phase_count + 5'd1 >= {2'b00, len}) begin
            phase_count_next = 5'd0;
            a_v = 1'b1;
            if (wide_seen) begin
              if (len == 3'd6) begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b1,
                                 {16'd0, operand_accum[23:8]},
                                 sext16({operand_accum[7:0], b}), '0, 1'b0);
              end else begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b1,
                                 {16'd0, word[15:0]}, '0, '0, 1'b0);
              end
            end else if (len == 3'd2) begin
              res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                               (current_opcode == OP_BIPUSH) ? sext8(b) : {24'd0, b},
                               '0, '0, 1'b0);
            end else if (len == 3'd3) begin
              if (current_opcode == OP_IINC) begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                                 {24'd0, operand_accum[7:0]}, sext8(b), '0, 1'b0);
              end else if (current_opcode == OP_SIPUSH) begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                                 sext16(word[15:0]), '0, '0, 1'b0);
              end else if ((current_opcode >= OP_IFEQ && current_opcode <= OP_JSR) ||
                           current_opcode == OP_IFNULL || current_opcode == OP_IFNONNULL) begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0, '0, '0,
                                 sext16(word[15:0]), 1'b1);
              end else begin
                res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                                 {16'd0, word[15:0]}, '0, '0, 1'b0);
              end
            end else if (len == 3'd4) begin
              res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                               {16'd0, operand_accum[15:0]}, {24'd0, b}, '0, 1'b0);
            end else if (current_opcode == OP_INVOKEINTERFACE) begin
              res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0,
                               {16'd0, operand_accum[23:8]}, {24'd0, operand_accum[7:0]},
                               '0, 1'b0);
              if (b != 8'd0) begin
                b_v   = 1'b1;
                res_b = make_res(KIND_BAD_PAD, pc32, current_opcode, 1'b0, {24'd0, b}, '0,
                                 '0, 1'b0);
              end
            end else begin
              res_a = make_res(KIND_INSTR, pc32, current_opcode, 1'b0, '0, '0, word, 1'b1);
            end
          end else begin
            operand_accum_next = word;
            phase_count_next   = phase_count + 5'd1;
          end
        end
      end

      // End of the method: report truncation, then return to reset state.
      if (byte_data.end_of_code) begin
        if (phase_count_next != 5'd0 && !skip_to_end_next) begin
          t_v   = 1'b1;
          res_t = make_res(KIND_TRUNCATED, 32'(insn_pc_next), current_opcode_next,
                           wide_seen_next, '0, '0, '0, 1'b0);
        end
        byte_offset_next    = '0;
        phase_count_next    = '0;
        current_opcode_next = '0;
        wide_seen_next      = 1'b0;
        insn_pc_next        = '0;
        operand_accum_next  = '0;
        default_offset_next = '0;
        switch_key_next     = '0;
        entries_left_next   = '0;
        skip_to_end_next    = 1'b0;
      end else begin
        byte_offset_next = byte_offset + PC_BITS'(1);
      end
    end
  end

  // Pack the candidate results into at most two queue slots.
  always_comb begin
    slot0 = '0;
    slot1 = '0;
    nres  = 2'd0;
    if (a_v) begin
      slot0 = res_a;
      nres  = 2'd1;
    end
    if (b_v) begin
      if (nres == 2'd0) begin
        slot0 = res_b;
      end else begin
        slot1 = res_b;
      end
      nres = nres + 2'd1;
    end
    if (t_v && nres != 2'd2) begin
      if (nres == 2'd0) begin
        slot0 = res_t;
      end else begin
        slot1 = res_t;
      end
      nres = nres + 2'd1;
    end
    if (nres == 2'd1) begin
      slot0.run_last = 1'b1;
    end else if (nres == 2'd2) begin
      slot1.run_last = 1'b1;
    end
  end

  always_comb begin
    count_next = count + QCW'(nres) - QCW'(pop);
  end

  // Decode state and queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset    <= '0;
      phase_count    <= '0;
      current_opcode <= '0;
      wide_seen      <= 1'b0;
      insn_pc        <= '0;
      operand_accum  <= '0;
      default_offset <= '0;
      switch_key     <= '0;
      entries_left   <= '0;
      skip_to_end    <= 1'b0;
      wr_ptr         <= '0;
      rd_ptr         <= '0;
      count          <= '0;
    end else begin
      byte_offset    <= byte_offset_next;
      phase_count    <= phase_count_next;
      current_opcode <= current_opcode_next;
      wide_seen      <= wide_seen_next;
      insn_pc        <= insn_pc_next;
      operand_accum  <= operand_accum_next;
      default_offset <= default_offset_next;
      switch_key     <= switch_key_next;
      entries_left   <= entries_left_next;
      skip_to_end    <= skip_to_end_next;
      wr_ptr         <= wr_ptr + QAW'(nres);
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  // Queue storage; nres is zero unless a byte was taken.
  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (nres == 2'd2) begin
      queue[wr_ptr + QAW'(1)] <= slot1;
    end
  end

  // A byte is only taken when the queue has room for two results.
  assert property (@(posedge clk) disable iff (rst)
    take |-> (count <= QCW'(QDEPTH - 2)))
    else $error("byte accepted without room for two results");

  // The end of a method returns the decoder to offset zero awaiting an opcode.
  assert property (@(posedge clk) disable iff (rst)
    (take && byte_data.end_of_code) |=>
      (byte_offset == '0 && phase_count == 5'd0 && !skip_to_end))
    else $error("decode state not cleared after end of code");

  // Switch entry phases only occur inside a switch instruction.
  assert property (@(posedge clk) disable iff (rst)
    (phase_count >= 5'd16) |->
      (!wide_seen && (current_opcode == OP_TABLESWITCH ||
                      current_opcode == OP_LOOKUPSWITCH)))
    else $error("switch entry phase outside a switch");

  // While skipping after an error no instruction is in progress.
  assert property (@(posedge clk) disable iff (rst)
    skip_to_end |-> (phase_count == 5'd0))
    else $error("instruction in progress while skipping");

endmodule
